// ===== rtl/ibet_pkg.sv =====
package ibet_pkg;

	// Field widths of one transaction
	localparam int OP_W    = 3;
	localparam int KEY_W   = 32;
	localparam int BTN_W   = 5;
	localparam int STICK_W = 8;
	localparam int AXIS_W  = 3;
	localparam int VAL_W   = 16;
	localparam int THR_W   = 16;
	localparam int OUT_W   = 32;

	// Threshold register value after reset
	localparam logic [THR_W-1:0] THR_RESET = 16'd8000;

	// Default sizes
	localparam int DEF_NUM_BUTTONS = 32;
	localparam int DEF_KEY_SLOTS   = 16;
	localparam int DEF_STICK_SLOTS = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_FRAME_CLR  = 3'd0;
	localparam logic [OP_W-1:0] OP_KEY_DOWN   = 3'd1;
	localparam logic [OP_W-1:0] OP_KEY_UP     = 3'd2;
	localparam logic [OP_W-1:0] OP_BTN_DOWN   = 3'd3;
	localparam logic [OP_W-1:0] OP_BTN_UP     = 3'd4;
	localparam logic [OP_W-1:0] OP_AXIS       = 3'd5;
	localparam logic [OP_W-1:0] OP_BIND_KEY   = 3'd6;
	localparam logic [OP_W-1:0] OP_BIND_STICK = 3'd7;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} ibet_cmd_t;

endpackage

// ===== rtl/ibet_ctrl.sv =====
module ibet_ctrl
	import ibet_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ibet_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic exec_go;

	// Take a transaction only when no item is in flight
	assign in_ready = (state_q == ST_IDLE);
	assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = exec_go;
	assign out_valid   = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (exec_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ibet_dp.sv =====
module ibet_dp
	import ibet_pkg::*;
#(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
	parameter int KEY_SLOTS   = DEF_KEY_SLOTS,
	parameter int STICK_SLOTS = DEF_STICK_SLOTS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ibet_cmd_t                cmd,
	input  logic                     cfg_wr_en,
	input  logic [THR_W-1:0]         cfg_wr_data,
	input  logic [OP_W-1:0]          op,
	input  logic [KEY_W-1:0]         key_code,
	input  logic [BTN_W-1:0]         button,
	input  logic [STICK_W-1:0]       stick_id,
	input  logic [AXIS_W-1:0]        axis,
	input  logic signed [VAL_W-1:0]  axis_value,
	input  logic                     direction,
	output logic [OUT_W-1:0]         held_bits,
	output logic [OUT_W-1:0]         pressed_bits,
	output logic [OUT_W-1:0]         released_bits,
	output logic                     bind_status
);

	localparam int FLAG_W = (NUM_BUTTONS > OUT_W) ? OUT_W : NUM_BUTTONS;
	localparam int MAG_W  = VAL_W + 1;

	// Item registers
	logic [OP_W-1:0]         op_q;
	logic [KEY_W-1:0]        key_q;
	logic [BTN_W-1:0]        btn_q;
	logic [STICK_W-1:0]      stick_q;
	logic [AXIS_W-1:0]       axis_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    dir_q;

	logic [THR_W-1:0]        thr_q;

	// Button flags
	logic [FLAG_W-1:0] held_q, pressed_q, released_q;
	logic [FLAG_W-1:0] held_d, pressed_d, released_d;

	// Binding tables
	logic [KEY_SLOTS-1:0]   key_vld_q;
	logic [KEY_W-1:0]       tbl_key_q  [KEY_SLOTS];
	logic [BTN_W-1:0]       tbl_kbtn_q [KEY_SLOTS];
	logic [STICK_SLOTS-1:0] st_vld_q;
	logic [STICK_W-1:0]     st_id_q    [STICK_SLOTS];
	logic [AXIS_W-1:0]      st_ax_q    [STICK_SLOTS];
	logic                   st_sign_q  [STICK_SLOTS];
	logic [BTN_W-1:0]       st_btn_q   [STICK_SLOTS];

	// Lookup results
	logic [KEY_SLOTS-1:0]   key_hit, key_free, key_we;
	logic [STICK_SLOTS-1:0] st_axis_hit, st_bind_hit, st_press_hit, st_free, st_we;
	logic [BTN_W-1:0]       key_btn, st_btn;
	logic [FLAG_W-1:0]      axis_rel_m;
	logic                   neg;
	logic [MAG_W-1:0]       mag;
	logic                   over_thr;

	logic [FLAG_W-1:0]      press_m, rel_m;
	logic                   clr;
	logic                   key_full, st_full, status_d;
	logic [OUT_W-1:0]       held_w, pressed_w, released_w;

	function automatic logic [FLAG_W-1:0] btn_mask(input logic [BTN_W-1:0] b);
		logic [FLAG_W-1:0] m;
		for (int j = 0; j < FLAG_W; j++) begin
			m[j] = (b == BTN_W'(j));
		end
		return m;
	endfunction

	// Compare the tables in parallel
	always_comb begin
		key_btn = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			key_hit[i] = key_vld_q[i] && (tbl_key_q[i] == key_q);
			if (key_hit[i]) key_btn = key_btn | tbl_kbtn_q[i];
		end
	end

	assign neg      = val_q[VAL_W-1];
	assign mag      = neg ? ((MAG_W'(1) << VAL_W) - {1'b0, val_q}) : {1'b0, val_q};
	assign over_thr = (mag >= {1'b0, thr_q});

	always_comb begin
		st_btn     = '0;
		axis_rel_m = '0;
		for (int i = 0; i < STICK_SLOTS; i++) begin
			st_axis_hit[i]  = st_vld_q[i] && (st_id_q[i] == stick_q) && (st_ax_q[i] == axis_q);
			st_bind_hit[i]  = st_axis_hit[i] && (st_sign_q[i] == dir_q);
			st_press_hit[i] = st_axis_hit[i] && (st_sign_q[i] == !neg);
			if (st_press_hit[i]) st_btn = st_btn | st_btn_q[i];
			if (st_axis_hit[i]) axis_rel_m = axis_rel_m | btn_mask(st_btn_q[i]);
		end
	end

	// Pick the slot a bind writes: its own entry, else the lowest free one
	assign key_free = ~key_vld_q;
	assign st_free  = ~st_vld_q;
	assign key_we   = (|key_hit) ? key_hit : (key_free & (~key_free + 1'b1));
	assign st_we    = (|st_bind_hit) ? st_bind_hit : (st_free & (~st_free + 1'b1));
	assign key_full = ~|key_we;
	assign st_full  = ~|st_we;

	// Decode the operation into press and release masks, frame clear and bind status
	always_comb begin
		press_m  = '0;
		rel_m    = '0;
		clr      = 1'b0;
		status_d = 1'b0;
		unique case (op_q)
			OP_FRAME_CLR:  clr = 1'b1;
			OP_KEY_DOWN:   if (|key_hit) press_m = btn_mask(key_btn);
			OP_KEY_UP:     if (|key_hit) rel_m = btn_mask(key_btn);
			OP_BTN_DOWN:   press_m = btn_mask(btn_q);
			OP_BTN_UP:     rel_m = btn_mask(btn_q);
			OP_AXIS: begin
				if (over_thr) begin
					if (|st_press_hit) press_m = btn_mask(st_btn);
				end else begin
					rel_m = axis_rel_m;
				end
			end
			OP_BIND_KEY:   status_d = key_full;
			OP_BIND_STICK: status_d = st_full;
			default:       clr = 1'b0;
		endcase
	end

	// Next flag values
	always_comb begin
		held_d     = (held_q | press_m) & ~rel_m;
		pressed_d  = clr ? '0 : ((pressed_q | (press_m & ~held_q)) & ~rel_m);
		released_d = clr ? '0 : ((released_q & ~press_m) | rel_m);
		held_w     = '0;
		pressed_w  = '0;
		released_w = '0;
		held_w[FLAG_W-1:0]     = held_d;
		pressed_w[FLAG_W-1:0]  = pressed_d;
		released_w[FLAG_W-1:0] = released_d;
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			key_q   <= key_code;
			btn_q   <= button;
			stick_q <= stick_id;
			axis_q  <= axis;
			val_q   <= axis_value;
			dir_q   <= direction;
		end
	end

	// Threshold register, flags and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			held_q     <= '0;
			pressed_q  <= '0;
			released_q <= '0;
			key_vld_q  <= '0;
			st_vld_q   <= '0;
		end else begin
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			if (cmd.execute) begin
				held_q     <= held_d;
				pressed_q  <= pressed_d;
				released_q <= released_d;
				if (op_q == OP_BIND_KEY) key_vld_q <= key_vld_q | key_we;
				if (op_q == OP_BIND_STICK) st_vld_q <= st_vld_q | st_we;
			end
		end
	end

	// Table payload
	always_ff @(posedge clk) begin
		if (cmd.execute && (op_q == OP_BIND_KEY)) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (key_we[i]) begin
					tbl_key_q[i]  <= key_q;
					tbl_kbtn_q[i] <= btn_q;
				end
			end
		end
		if (cmd.execute && (op_q == OP_BIND_STICK)) begin
			for (int i = 0; i < STICK_SLOTS; i++) begin
				if (st_we[i]) begin
					st_id_q[i]   <= stick_q;
					st_ax_q[i]   <= axis_q;
					st_sign_q[i] <= dir_q;
					st_btn_q[i]  <= btn_q;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			held_bits     <= held_w;
			pressed_bits  <= pressed_w;
			released_bits <= released_w;
			bind_status   <= status_d;
		end
	end

endmodule

// ===== rtl/input_binding_edge_tracker_unit.sv =====
// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------------------------
// input     | in_valid / in_ready     | op, key_code, button, stick_id, axis,
//           |                         | axis_value, direction
// result    | out_valid / out_ready   | held_bits, pressed_bits, released_bits,
//           |                         | bind_status
// config    | cfg_wr_en (no wait)     | cfg_wr_data = stick_threshold
//
// Each transaction is first captured into the item registers; then the key and stick
// tables are compared in parallel and the flags and result register update.
// A new item is taken the cycle after the result is written.
// Reset clears all flags and table valid bits and sets the threshold to 8000.
// A result not yet taken stalls execution of the next item, not its capture.
module input_binding_edge_tracker_unit
	import ibet_pkg::*;
#(
	parameter int NUM_BUTTONS = DEF_NUM_BUTTONS,
	parameter int KEY_SLOTS   = DEF_KEY_SLOTS,
	parameter int STICK_SLOTS = DEF_STICK_SLOTS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [THR_W-1:0]        cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         op,
	input  logic [KEY_W-1:0]        key_code,
	input  logic [BTN_W-1:0]        button,
	input  logic [STICK_W-1:0]      stick_id,
	input  logic [AXIS_W-1:0]       axis,
	input  logic signed [VAL_W-1:0] axis_value,
	input  logic                    direction,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OUT_W-1:0]        held_bits,
	output logic [OUT_W-1:0]        pressed_bits,
	output logic [OUT_W-1:0]        released_bits,
	output logic                    bind_status
);

	ibet_cmd_t cmd;

	ibet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ibet_dp #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.KEY_SLOTS   (KEY_SLOTS),
		.STICK_SLOTS (STICK_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.op            (op),
		.key_code      (key_code),
		.button        (button),
		.stick_id      (stick_id),
		.axis          (axis),
		.axis_value    (axis_value),
		.direction     (direction),
		.held_bits     (held_bits),
		.pressed_bits  (pressed_bits),
		.released_bits (released_bits),
		.bind_status   (bind_status)
	);

	// One item in flight: no capture right after a capture
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	// A newly pressed button is always held
	a_pressed_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_bits & ~held_bits) == '0))
		else $error("pressed flag set on a button that is not held");

	// A released button is never held
	a_released_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((released_bits & held_bits) == '0))
		else $error("button both held and released");

endmodule

// ===== tb/sv/tb_input_binding_edge_tracker_unit.sv =====
`timescale 1ns / 1ps

module tb_input_binding_edge_tracker_unit;
	import ibet_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int KEY_POOL       = 24;
	localparam int STICK_POOL     = 12;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 160;

	// One input transaction, field by field
	typedef struct {
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        key;
		logic [BTN_W-1:0]        btn;
		logic [STICK_W-1:0]      stick;
		logic [AXIS_W-1:0]       axis;
		logic signed [VAL_W-1:0] value;
		logic                    dir;
	} input_item_t;

	// One result transaction
	typedef struct packed {
		logic [OUT_W-1:0] held;
		logic [OUT_W-1:0] pressed;
		logic [OUT_W-1:0] released;
		logic             status;
	} flag_rec_t;

	// Tracks button flags and binding tables, and queues the flags each item should report
	class flag_scoreboard;
		flag_rec_t        flags_q[$];
		logic [THR_W-1:0] threshold;
		logic [OUT_W-1:0] held;
		logic [OUT_W-1:0] pressed;
		logic [OUT_W-1:0] released;
		bit               key_used[DEF_KEY_SLOTS];
		logic [KEY_W-1:0] key_code_tab[DEF_KEY_SLOTS];
		logic [BTN_W-1:0] key_btn_tab[DEF_KEY_SLOTS];
		bit               stk_used[DEF_STICK_SLOTS];
		logic [STICK_W-1:0] stk_id_tab[DEF_STICK_SLOTS];
		logic [AXIS_W-1:0]  stk_axis_tab[DEF_STICK_SLOTS];
		logic               stk_sign_tab[DEF_STICK_SLOTS];
		logic [BTN_W-1:0]   stk_btn_tab[DEF_STICK_SLOTS];
		int errors;
		int results_seen;
		int full_hits;
		int op_count[8];

		function new();
			threshold = THR_RESET;
			held = '0;
			pressed = '0;
			released = '0;
			errors = 0;
			results_seen = 0;
			full_hits = 0;
			foreach (op_count[i]) op_count[i] = 0;
			foreach (key_used[i]) key_used[i] = 1'b0;
			foreach (stk_used[i]) stk_used[i] = 1'b0;
		endfunction

		function void press_btn(logic [BTN_W-1:0] b);
			logic [OUT_W-1:0] m;
			if (int'(b) >= DEF_NUM_BUTTONS) return;
			m = 32'd1 << b;
			if ((held & m) == '0) pressed |= m;
			held |= m;
			released &= ~m;
		endfunction

		function void drop_btn(logic [BTN_W-1:0] b);
			logic [OUT_W-1:0] m;
			if (int'(b) >= DEF_NUM_BUTTONS) return;
			m = 32'd1 << b;
			pressed &= ~m;
			held &= ~m;
			released |= m;
		endfunction

		function int find_key(logic [KEY_W-1:0] k);
			for (int i = 0; i < DEF_KEY_SLOTS; i++)
				if (key_used[i] && key_code_tab[i] == k) return i;
			return -1;
		endfunction

		function int find_stick(logic [STICK_W-1:0] s, logic [AXIS_W-1:0] a, logic sign);
			for (int i = 0; i < DEF_STICK_SLOTS; i++)
				if (stk_used[i] && stk_id_tab[i] == s && stk_axis_tab[i] == a &&
				    stk_sign_tab[i] == sign) return i;
			return -1;
		endfunction

		// Apply one accepted item and queue the flags it should produce
		function void note_input(input_item_t it);
			flag_rec_t rec;
			logic [VAL_W:0] mag;
			logic neg;
			int slot;
			rec.status = 1'b0;
			op_count[it.op]++;
			case (it.op)
				OP_FRAME_CLR: begin
					pressed = '0;
					released = '0;
				end
				OP_KEY_DOWN: begin
					slot = find_key(it.key);
					if (slot >= 0) press_btn(key_btn_tab[slot]);
				end
				OP_KEY_UP: begin
					slot = find_key(it.key);
					if (slot >= 0) drop_btn(key_btn_tab[slot]);
				end
				OP_BTN_DOWN: press_btn(it.btn);
				OP_BTN_UP:   drop_btn(it.btn);
				OP_AXIS: begin
					neg = it.value[VAL_W-1];
					mag = neg ? (17'h10000 - {1'b0, it.value}) : {1'b0, it.value};
					if (mag >= {1'b0, threshold}) begin
						slot = find_stick(it.stick, it.axis, !neg);
						if (slot >= 0) press_btn(stk_btn_tab[slot]);
					end else begin
						// below threshold: drop every binding on this stick and axis
						for (int i = 0; i < DEF_STICK_SLOTS; i++)
							if (stk_used[i] && stk_id_tab[i] == it.stick &&
							    stk_axis_tab[i] == it.axis) drop_btn(stk_btn_tab[i]);
					end
				end
				OP_BIND_KEY: begin
					slot = find_key(it.key);
					if (slot < 0) begin
						slot = 0;
						while (slot < DEF_KEY_SLOTS && key_used[slot]) slot++;
					end
					if (slot >= DEF_KEY_SLOTS) begin
						rec.status = 1'b1;
						full_hits++;
					end else begin
						key_used[slot] = 1'b1;
						key_code_tab[slot] = it.key;
						key_btn_tab[slot] = it.btn;
					end
				end
				default: begin
					slot = find_stick(it.stick, it.axis, it.dir);
					if (slot < 0) begin
						slot = 0;
						while (slot < DEF_STICK_SLOTS && stk_used[slot]) slot++;
					end
					if (slot >= DEF_STICK_SLOTS) begin
						rec.status = 1'b1;
						full_hits++;
					end else begin
						stk_used[slot] = 1'b1;
						stk_id_tab[slot] = it.stick;
						stk_axis_tab[slot] = it.axis;
						stk_sign_tab[slot] = it.dir;
						stk_btn_tab[slot] = it.btn;
					end
				end
			endcase
			rec.held = held;
			rec.pressed = pressed;
			rec.released = released;
			flags_q.push_back(rec);
		endfunction

		// Compare one accepted result with the oldest queued flags
		function void check_result(flag_rec_t got);
			flag_rec_t want;
			results_seen++;
			if (flags_q.size() == 0) begin
				$error("result with no item pending: held %h pressed %h released %h status %b",
				       got.held, got.pressed, got.released, got.status);
				errors++;
				return;
			end
			want = flags_q.pop_front();
			if (got.held !== want.held) begin
				$error("held_bits: expected %h, actual %h", want.held, got.held);
				errors++;
			end
			if (got.pressed !== want.pressed) begin
				$error("pressed_bits: expected %h, actual %h", want.pressed, got.pressed);
				errors++;
			end
			if (got.released !== want.released) begin
				$error("released_bits: expected %h, actual %h", want.released, got.released);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("bind_status: expected %b, actual %b", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [THR_W-1:0]        cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         op = '0;
	logic [KEY_W-1:0]        key_code = '0;
	logic [BTN_W-1:0]        button = '0;
	logic [STICK_W-1:0]      stick_id = '0;
	logic [AXIS_W-1:0]       axis = '0;
	logic signed [VAL_W-1:0] axis_value = '0;
	logic                    direction = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [OUT_W-1:0]        held_bits;
	logic [OUT_W-1:0]        pressed_bits;
	logic [OUT_W-1:0]        released_bits;
	logic                    bind_status;

	flag_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int thr_settings = 1;

	logic [KEY_W-1:0]   key_pool[KEY_POOL];
	logic [STICK_W-1:0] stick_pool_id[STICK_POOL];
	logic [AXIS_W-1:0]  stick_pool_axis[STICK_POOL];

	input_binding_edge_tracker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.key_code      (key_code),
		.button        (button),
		.stick_id      (stick_id),
		.axis          (axis),
		.axis_value    (axis_value),
		.direction     (direction),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.held_bits     (held_bits),
		.pressed_bits  (pressed_bits),
		.released_bits (released_bits),
		.bind_status   (bind_status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one transaction, after a random gap, and hold it until accepted
	task automatic drive_item(input input_item_t it);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		op         <= it.op;
		key_code   <= it.key;
		button     <= it.btn;
		stick_id   <= it.stick;
		axis       <= it.axis;
		axis_value <= it.value;
		direction  <= it.dir;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	// Stop offering and wait until every queued result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.flags_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.threshold = v;
		thr_settings++;
	endtask

	function automatic input_item_t mk(logic [OP_W-1:0] o, logic [KEY_W-1:0] k,
	                                   logic [BTN_W-1:0] b, logic [STICK_W-1:0] s,
	                                   logic [AXIS_W-1:0] a, logic signed [VAL_W-1:0] v,
	                                   logic d);
		input_item_t it;
		it.op = o;
		it.key = k;
		it.btn = b;
		it.stick = s;
		it.axis = a;
		it.value = v;
		it.dir = d;
		return it;
	endfunction

	// Mostly keys and sticks from the pools, with a share of raw noise
	function automatic input_item_t make_random_item();
		input_item_t it;
		int r;
		int m;
		int j;
		r = $urandom_range(0, 99);
		it.key = $urandom;
		it.btn = BTN_W'($urandom);
		it.stick = STICK_W'($urandom);
		it.axis = AXIS_W'($urandom);
		it.value = VAL_W'($urandom);
		it.dir = 1'($urandom);
		if (r < 7)       it.op = OP_FRAME_CLR;
		else if (r < 27) it.op = OP_KEY_DOWN;
		else if (r < 42) it.op = OP_KEY_UP;
		else if (r < 54) it.op = OP_BTN_DOWN;
		else if (r < 64) it.op = OP_BTN_UP;
		else if (r < 86) it.op = OP_AXIS;
		else if (r < 93) it.op = OP_BIND_KEY;
		else             it.op = OP_BIND_STICK;
		if ($urandom_range(0, 99) < 85) it.key = key_pool[$urandom_range(0, KEY_POOL-1)];
		if ($urandom_range(0, 99) < 85) begin
			j = $urandom_range(0, STICK_POOL-1);
			it.stick = stick_pool_id[j];
			it.axis = stick_pool_axis[j];
		end
		case ($urandom_range(0, 3))
			0: it.value = VAL_W'($urandom);
			1: begin
				// straddle the threshold
				m = int'(sb.threshold) + int'($urandom_range(0, 4)) - 2;
				if (m < 0) m = 0;
				if (m > 32768) m = 32768;
				it.value = $urandom_range(0, 1) ? VAL_W'(-m) : VAL_W'(m);
			end
			2: begin
				m = $urandom_range(0, 255);
				it.value = $urandom_range(0, 1) ? VAL_W'(-m) : VAL_W'(m);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: it.value = 16'sh8000;
					1: it.value = 16'sh7FFF;
					2: it.value = 16'sh0000;
					default: it.value = -16'sd1;
				endcase
			end
		endcase
		return it;
	endfunction

	// Result side: check every accepted result, stall at random, and once hold off long
	initial begin
		flag_rec_t got;
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.held = held_bits;
				got.pressed = pressed_bits;
				got.released = released_bits;
				got.status = bind_status;
				sb.check_result(got);
			end
			if (hold_request && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Main sequence: reset, directed items, then random phases over several thresholds
	initial begin
		int thr_plan[PHASES];
		thr_plan = '{8000, 0, 32768, 0, 1, 32767, 16000, 0};
		thr_plan[3] = $urandom_range(0, 32768);
		thr_plan[7] = $urandom_range(0, 32768);
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
		stick_pool_id[0] = 8'hFF;
		stick_pool_axis[0] = 3'd7;
		stick_pool_id[1] = 8'h00;
		stick_pool_axis[1] = 3'd0;
		for (int i = 2; i < STICK_POOL; i++) begin
			stick_pool_id[i] = STICK_W'($urandom);
			stick_pool_axis[i] = AXIS_W'($urandom);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unbound key, binds at key extremes, repeated press, frame clear, rebinding
		drive_item(mk(OP_KEY_DOWN,   32'h0000_0000, 5'd3,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_BIND_KEY,   32'h0000_0000, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_BIND_KEY,   32'hFFFF_FFFF, 5'd31, 8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_DOWN,   32'h0000_0000, 5'd9,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_DOWN,   32'h0000_0000, 5'd9,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_DOWN,   32'hFFFF_FFFF, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_FRAME_CLR,  32'h0000_0000, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_DOWN,   32'h0000_0000, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_UP,     32'hFFFF_FFFF, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_BIND_KEY,   32'h0000_0000, 5'd5,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_KEY_UP,     32'h0000_0000, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_BTN_DOWN,   32'hFFFF_FFFF, 5'd31, 8'hFF,  3'd7, -16'sd1, 1'b1));
		drive_item(mk(OP_BTN_UP,     32'h0000_0000, 5'd0,  8'd0,   3'd0, 16'sd0, 1'b0));
		// stick binds at both signs, threshold edges and full-scale values
		drive_item(mk(OP_BIND_STICK, 32'h0000_0000, 5'd7,  8'hFF,  3'd7, 16'sd0, 1'b1));
		drive_item(mk(OP_BIND_STICK, 32'h0000_0000, 5'd8,  8'hFF,  3'd7, 16'sd0, 1'b0));
		drive_item(mk(OP_BIND_STICK, 32'h0000_0000, 5'd9,  8'h00,  3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'hFF,  3'd7, 16'sh7FFF, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'hFF,  3'd7, 16'sh8000, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'hFF,  3'd7, 16'sd7999, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'hFF,  3'd7, 16'sd8000, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'hFF,  3'd7, -16'sd8000, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'h00,  3'd0, 16'sd0, 1'b0));
		drive_item(mk(OP_AXIS,       32'h0000_0000, 5'd0,  8'h03,  3'd2, 16'sd20000, 1'b0));
		drive_item(mk(OP_FRAME_CLR,  32'hFFFF_FFFF, 5'd31, 8'hFF,  3'd7, 16'sh8000, 1'b1));

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			if (phase > 0) write_threshold(THR_W'(thr_plan[phase]));
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (phase == 2 && n == 40) hold_request = 1'b1;
				drive_item(make_random_item());
			end
		end

		drain();
		repeat (10) @(posedge clk);

		$display("summary: %0d results checked over %0d threshold settings and four idle patterns",
		         sb.results_seen, thr_settings);
		$display("summary: ops clr %0d kdn %0d kup %0d bdn %0d bup %0d axis %0d bk %0d bs %0d, full %0d",
		         sb.op_count[OP_FRAME_CLR], sb.op_count[OP_KEY_DOWN], sb.op_count[OP_KEY_UP],
		         sb.op_count[OP_BTN_DOWN], sb.op_count[OP_BTN_UP], sb.op_count[OP_AXIS],
		         sb.op_count[OP_BIND_KEY], sb.op_count[OP_BIND_STICK], sb.full_hits);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
